[src/tlbr_pkg.sv]
package tlbr_pkg;

   // Configuration register indexes
   localparam logic [2:0] RegStartX    = 3'd0;
   localparam logic [2:0] RegStartY    = 3'd1;
   localparam logic [2:0] RegEndX      = 3'd2;
   localparam logic [2:0] RegEndY      = 3'd3;
   localparam logic [2:0] RegLineWidth = 3'd4;
   localparam logic [2:0] RegClipToBox = 3'd5;

   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 7;
   localparam int XCoordW  = 7;
   localparam int YCoordW  = 6;
   localparam int LineWW   = 6;
   localparam int ReqDataW = 8;
   localparam int RspDataW = 16;

   typedef struct packed {
      logic [XCoordW-1:0] start_x;
      logic [YCoordW-1:0] start_y;
      logic [XCoordW-1:0] end_x;
      logic [YCoordW-1:0] end_y;
      logic [LineWW-1:0]  line_width;
      logic               clip_to_box;
   } cfg_type;

endpackage

[src/thick_line_box_scan_rasterizer.sv]
// Thick line raster scanner: one pixel decision per req beat.
// Path: an accepted beat is written into the queue, registered in the product stage
// (stage 1), then compared and held in the output register that drives rsp.
// One beat per cycle unless rsp stalls; a 2-entry queue decouples scan and compare.
// Reset (synchronous, active high): scan restarts at the window origin, queue
// and pipeline empty, registers at defaults (width 1, clipping on).
module thick_line_box_scan_rasterizer #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: [0] restart
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tlbr_pkg::ReqDataW-1:0]  req_tdata,
   // rsp_tdata: [6:0] pixel_x, [12:7] pixel_y, [13] lit, [15:14] zero
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tlbr_pkg::RspDataW-1:0]  rsp_tdata,
   output logic                           rsp_tlast,
   input  logic                           csr_wr_en,
   input  logic [tlbr_pkg::CsrAddrW-1:0]  csr_addr,
   input  logic [tlbr_pkg::CsrDataW-1:0]  csr_wr_data
);

   localparam int ColW   = ($clog2(SCREEN_WIDTH) > tlbr_pkg::XCoordW) ?
                           $clog2(SCREEN_WIDTH) : tlbr_pkg::XCoordW;
   localparam int RowW   = ($clog2(SCREEN_HEIGHT) > tlbr_pkg::YCoordW) ?
                           $clog2(SCREEN_HEIGHT) : tlbr_pkg::YCoordW;
   localparam int EntryW = ColW + RowW + 1;

   // Defaults: start_x, start_y, end_x, end_y zero, width 1, clipping on
   localparam tlbr_pkg::cfg_type CfgReset = {7'd0, 6'd0, 7'd0, 6'd0, 6'd1, 1'b1};

   tlbr_pkg::cfg_type cfg_ff, cfg_in;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            tlbr_pkg::RegStartX:    cfg_in.start_x     = csr_wr_data[6:0];
            tlbr_pkg::RegStartY:    cfg_in.start_y     = csr_wr_data[5:0];
            tlbr_pkg::RegEndX:      cfg_in.end_x       = csr_wr_data[6:0];
            tlbr_pkg::RegEndY:      cfg_in.end_y       = csr_wr_data[5:0];
            tlbr_pkg::RegLineWidth: cfg_in.line_width  = csr_wr_data[5:0];
            tlbr_pkg::RegClipToBox: cfg_in.clip_to_box = csr_wr_data[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   logic              q_full, q_not_empty, q_pop, push_valid, push_last;
   logic [ColW-1:0]   push_x;
   logic [RowW-1:0]   push_y;
   logic [EntryW-1:0] q_rd_data;

   tlbr_front #(
      .ScreenW (SCREEN_WIDTH),
      .ScreenH (SCREEN_HEIGHT),
      .ColW    (ColW),
      .RowW    (RowW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_tvalid),
      .req_restart (req_tdata[0]),
      .req_ready   (req_tready),
      .q_full      (q_full),
      .push_valid  (push_valid),
      .push_x      (push_x),
      .push_y      (push_y),
      .push_last   (push_last)
   );

   tlbr_fifo #(
      .Width (EntryW),
      .Depth (2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (push_valid),
      .wr_data   ({push_last, push_y, push_x}),
      .rd_en     (q_pop),
      .rd_data   (q_rd_data),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   tlbr_back #(
      .ColW (ColW),
      .RowW (RowW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_not_empty),
      .q_x        (q_rd_data[ColW-1:0]),
      .q_y        (q_rd_data[ColW+RowW-1:ColW]),
      .q_last     (q_rd_data[EntryW-1]),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[src/tlbr_fifo.sv]
module tlbr_fifo #(
   parameter int Width = 15,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   output logic [Width-1:0] rd_data,
   output logic             full,
   output logic             not_empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign full      = (count_ff == CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign rd_data   = mem_ff[rd_ptr_ff];

   // Advance pointers and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store incoming beat
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue fill level beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !wr_en)
      else $error("write into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !rd_en)
      else $error("read from empty queue");
`endif

endmodule

[src/tlbr_front.sv]
module tlbr_front #(
   parameter int ScreenW = 128,
   parameter int ScreenH = 64,
   parameter int ColW    = 7,
   parameter int RowW    = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tlbr_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   input  logic                 req_restart,
   output logic                 req_ready,
   input  logic                 q_full,
   output logic                 push_valid,
   output logic [ColW-1:0]      push_x,
   output logic [RowW-1:0]      push_y,
   output logic                 push_last
);

   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;
   logic            active_ff, active_in;

   logic [ColW-1:0] xlo, xhi, px;
   logic [RowW-1:0] ylo, yhi, py;
   logic            start, wrap, bottom, accept;

   // Window bounds: endpoint box or whole screen
   always_comb begin
      if (cfg.clip_to_box) begin
         xlo = (cfg.start_x < cfg.end_x) ? ColW'(cfg.start_x) : ColW'(cfg.end_x);
         xhi = (cfg.start_x < cfg.end_x) ? ColW'(cfg.end_x) : ColW'(cfg.start_x);
         ylo = (cfg.start_y < cfg.end_y) ? RowW'(cfg.start_y) : RowW'(cfg.end_y);
         yhi = (cfg.start_y < cfg.end_y) ? RowW'(cfg.end_y) : RowW'(cfg.start_y);
      end else begin
         xlo = '0;
         xhi = ColW'(ScreenW - 1);
         ylo = '0;
         yhi = RowW'(ScreenH - 1);
      end
   end

   assign req_ready  = !q_full;
   assign accept     = req_valid && req_ready;
   assign push_valid = accept;

   // Pick current pixel and step the raster position
   always_comb begin
      start     = req_restart || !active_ff;
      px        = start ? xlo : col_ff;
      py        = start ? ylo : row_ff;
      wrap      = (px >= xhi);
      bottom    = (py >= yhi);
      push_x    = px;
      push_y    = py;
      push_last = wrap && bottom;
      col_in    = col_ff;
      row_in    = row_ff;
      active_in = active_ff;
      if (accept) begin
         col_in    = wrap ? xlo : px + 1'b1;
         row_in    = (wrap && !bottom) ? py + 1'b1 : py;
         active_in = !(wrap && bottom);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         active_ff <= active_in;
      end
   end

`ifndef SYNTH
   a_end_of_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && push_last) |=> !active_ff)
      else $error("scan still active after last pixel");

   a_mid_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && !push_last) |=> active_ff)
      else $error("scan dropped before last pixel");
`endif

endmodule

[src/tlbr_back.sv]
module tlbr_back #(
   parameter int ColW = 7,
   parameter int RowW = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tlbr_pkg::cfg_type              cfg,
   input  logic                           q_valid,
   input  logic [ColW-1:0]                q_x,
   input  logic [RowW-1:0]                q_y,
   input  logic                           q_last,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tlbr_pkg::RspDataW-1:0]  rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int DiffW = ((ColW > RowW) ? ColW : RowW) + 2;
   localparam int ProdW = DiffW + 8;
   localparam int SumW  = ProdW + 1;

   // Slope terms, sign-normalized so the x step is non-negative
   logic signed [7:0]       dx, dxa;
   logic signed [6:0]       dy, dys;
   logic signed [DiffW-1:0] x_s, x0_s, y_s, y0_s, half_lo_s, half_hi_s;
   logic signed [DiffW-1:0] xdiff, ydiff;
   logic signed [ProdW-1:0] p_line, p_low, p_span;
   logic                    vert_lit;

   assign dx  = 8'(cfg.end_x) - 8'(cfg.start_x);
   assign dxa = dx[7] ? -dx : dx;
   assign dy  = 7'(cfg.end_y) - 7'(cfg.start_y);
   assign dys = dx[7] ? -dy : dy;

   assign x_s       = DiffW'(q_x);
   assign x0_s      = DiffW'(cfg.start_x);
   assign y_s       = DiffW'(q_y);
   assign y0_s      = DiffW'(cfg.start_y);
   assign half_lo_s = DiffW'(cfg.line_width >> 1);
   assign half_hi_s = (cfg.line_width == '0) ? -DiffW'(1) :
                      DiffW'((cfg.line_width - 1'b1) >> 1);

   assign xdiff = x_s - x0_s;
   assign ydiff = y_s - y0_s - half_lo_s;

   // Cross-multiplied bounds relative to the start point
   assign p_line = ProdW'(dys) * ProdW'(xdiff);
   assign p_low  = ProdW'(ydiff) * ProdW'(dxa);
   assign p_span = ProdW'(cfg.line_width) * ProdW'(dxa);

   // Vertical line: column band around start_x
   assign vert_lit = ((xdiff + half_hi_s) >= 0) && (xdiff <= half_lo_s);

   // Stage 1 registers
   logic                    s1_valid_ff, s1_valid_in;
   logic [ColW-1:0]         s1_x_ff;
   logic [RowW-1:0]         s1_y_ff;
   logic                    s1_last_ff, s1_vert_ff, s1_vlit_ff;
   logic signed [ProdW-1:0] s1_line_ff, s1_low_ff, s1_span_ff;

   // Output registers
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tlbr_pkg::RspDataW-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff;

   logic                   out_en, s1_en, lit;
   logic signed [SumW-1:0] high_bound;

   assign out_en = !rsp_valid_ff || rsp_tready;
   assign s1_en  = !s1_valid_ff || out_en;
   assign q_pop  = q_valid && s1_en;

   assign s1_valid_in  = s1_en ? q_valid : s1_valid_ff;
   assign rsp_valid_in = out_en ? s1_valid_ff : rsp_valid_ff;

   // Final compare against the band
   always_comb begin
      high_bound  = SumW'(s1_low_ff) + SumW'(s1_span_ff);
      lit         = s1_vert_ff ? s1_vlit_ff :
                    ((s1_line_ff >= s1_low_ff) && (SumW'(s1_line_ff) < high_bound));
      rsp_data_in = {2'b00, lit, s1_y_ff[tlbr_pkg::YCoordW-1:0],
                     s1_x_ff[tlbr_pkg::XCoordW-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load payloads when each stage moves
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_x_ff    <= q_x;
         s1_y_ff    <= q_y;
         s1_last_ff <= q_last;
         s1_vert_ff <= (dx == 8'sd0);
         s1_vlit_ff <= vert_lit;
         s1_line_ff <= p_line;
         s1_low_ff  <= p_low;
         s1_span_ff <= p_span;
      end
      if (out_en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_en) |=> s1_valid_ff)
      else $error("stage 1 beat lost under stall");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> s1_valid_ff)
      else $error("popped beat not captured");
`endif

endmodule
